// ===== rtl/core/tdsi_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsi_pkg: shared types and constants of the spin integrator
// Register indexes, reset values and the divider request and response types.
// ----------------------------------------------------------------------------
package tdsi_pkg;

  localparam logic [1:0] RegInvInertia = 2'd0;
  localparam logic [1:0] RegMaxSpeed   = 2'd1;
  localparam logic [1:0] RegDamping    = 2'd2;
  localparam logic [1:0] RegRestThr    = 2'd3;

  localparam logic [30:0] InvInertiaReset = 31'd163840;
  localparam logic [30:0] MaxSpeedReset   = 31'd655360;
  localparam logic [16:0] DampingReset    = 17'd6554;
  localparam logic [15:0] RestThrReset    = 16'd1;

  localparam logic signed [31:0] SpinResetX = 32'sd0;
  localparam logic signed [31:0] SpinResetY = 32'sd13107;
  localparam logic signed [31:0] SpinResetZ = 32'sd19661;

  // Divider request: signed numerator, positive divisor, truncating quotient.
  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic        [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/tdsi_div.sv =====
// ----------------------------------------------------------------------------
// tdsi_div: shared restoring divider
// Divides a signed 64-bit numerator by a positive 32-bit divisor, truncating
// toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdsi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdsi_pkg::div_req_t req_i,
  output tdsi_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [63:0] mag;

  assign mag = req_i.num[63] ? (64'd0 - 64'(req_i.num)) : 64'(req_i.num);
  assign trial = {rem_q[31:0], quo_q[63]};

  // One shift and trial subtract a cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      quo_d  = mag;
      rem_d  = 33'd0;
      den_d  = req_i.den;
      neg_d  = req_i.num[63];
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? (64'sd0 - $signed(quo_q)) : $signed(quo_q);

endmodule

// ===== rtl/core/tdsi_sqrt.sv =====
// ----------------------------------------------------------------------------
// tdsi_sqrt: iterative integer square root
// Floor square root of a 66-bit sum, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tdsi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] rad_i,
  output logic        done_o,
  output logic [32:0] root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [65:0] rad_q, rad_d;
  logic [34:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic [34:0] trial;
  logic [34:0] cand;

  assign trial = {rem_q[32:0], rad_q[65:64]};
  assign cand  = {root_q, 2'b01};

  // Digit-by-digit recurrence, one result bit a cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rad_d  = rad_i;
      rem_d  = 35'd0;
      root_d = 33'd0;
    end else if (busy_q) begin
      rad_d = {rad_q[63:0], 2'b00};
      if (trial >= cand) begin
        rem_d  = trial - cand;
        root_d = {root_q[31:0], 1'b1};
      end else begin
        rem_d  = trial;
        root_d = {root_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/torque_driven_spin_integrator.sv =====
// ----------------------------------------------------------------------------
// torque_driven_spin_integrator: angular velocity update per haptic tick
// Lever-arm torque, inverse inertia, Euler step, speed cap, damping, halt,
// then unit axis and turn angle, all from one shared multiplier under a
// sequencer, with a shared divider and square root unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Content
// s_axis   in   s_axis_tvalid/tready   one tick request
// m_axis   out  m_axis_tvalid/tready   velocity, axis and angle
// cfg      in   cfg_valid_i/ready_o    register index and value
//
// Each of up to six divisions waits on the divider, and each of the two speed
// roots waits on the root unit; three divisions run when the speed is over the
// cap and three when it is above the rest threshold. The input is not ready
// from acceptance until the result has been taken. Reset clears the velocity
// to its start value and the registers to their defaults.
// ----------------------------------------------------------------------------
module torque_driven_spin_integrator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: tool_px, tool_py, tool_pz, centre_px, centre_py, centre_pz,
  //        push_fx, push_fy, push_fz, step_time (bits 303:288)
  input  logic [303:0] s_axis_tdata,
  // tuser: halt_switch
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: spin_x, spin_y, spin_z, axis_ux, axis_uy, axis_uz, turn_angle,
  //        zero fill (bits 183:181)
  output logic [183:0] m_axis_tdata,
  // tuser: turn_valid
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StCross = 5'd1;
  localparam logic [4:0] StAcc   = 5'd2;
  localparam logic [4:0] StInt   = 5'd3;
  localparam logic [4:0] StSq1   = 5'd4;
  localparam logic [4:0] StRt1   = 5'd5;
  localparam logic [4:0] StCapM  = 5'd6;
  localparam logic [4:0] StCapD  = 5'd7;
  localparam logic [4:0] StDamp  = 5'd8;
  localparam logic [4:0] StLoss  = 5'd9;
  localparam logic [4:0] StSq2   = 5'd10;
  localparam logic [4:0] StRt2   = 5'd11;
  localparam logic [4:0] StAxD   = 5'd12;
  localparam logic [4:0] StAng   = 5'd13;
  localparam logic [4:0] StOut   = 5'd14;
  localparam logic [4:0] StDWait = 5'd15;
  localparam logic [4:0] StRWait = 5'd16;

  logic [4:0] st_q, st_d, ret_q, ret_d;
  logic [2:0] k_q, k_d;

  logic [30:0] inv_q;
  logic [30:0] maxs_q;
  logic [16:0] damp_q;
  logic [15:0] rest_q;

  logic signed [31:0] spin_q [3];
  logic signed [31:0] spin_d [3];
  logic signed [32:0] v_q [3];
  logic signed [32:0] f_q [3];
  logic signed [31:0] tq_q [3];
  logic signed [31:0] tq_d [3];
  logic signed [17:0] ax_q [3];
  logic signed [17:0] ax_d [3];
  logic signed [66:0] acc_q, acc_d;
  logic [15:0] step_q;
  logic        halt_q;
  logic [32:0] speed_q, speed_d;
  logic [30:0] ang_q, ang_d;
  logic        tv_q, tv_d;
  logic [16:0] fac_q, fac_d;

  // Shared multiplier: 33 x 33 signed, combinational.
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  assign prod = ma * mb;

  tdsi_pkg::div_req_t dreq;
  tdsi_pkg::div_rsp_t drsp;
  logic        sq_start;
  logic        sq_done;
  logic [32:0] sq_root;

  tdsi_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));
  tdsi_sqrt u_sqrt (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(sq_start),
                    .rad_i(acc_d[65:0]), .done_o(sq_done), .root_o(sq_root));

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) return 32'sh7fffffff;
    if (x < -67'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Cross-product operand indexes per step (torque term, minuend or not).
  function automatic logic [1:0] cra(input logic [2:0] s);
    case (s)
      3'd0: return 2'd1; 3'd1: return 2'd2; 3'd2: return 2'd2;
      3'd3: return 2'd0; 3'd4: return 2'd0; default: return 2'd1;
    endcase
  endfunction
  function automatic logic [1:0] crb(input logic [2:0] s);
    case (s)
      3'd0: return 2'd2; 3'd1: return 2'd1; 3'd2: return 2'd0;
      3'd3: return 2'd2; 3'd4: return 2'd1; default: return 2'd0;
    endcase
  endfunction

  logic [1:0] ki;
  assign ki = k_q[1:0];
  logic signed [66:0] fq;
  assign fq = {{17{prod[65]}}, prod[65:16]};

  assign s_axis_tready = (st_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  // Sequencer.
  always_comb begin
    st_d = st_q; ret_d = ret_q; k_d = k_q;
    acc_d = acc_q; speed_d = speed_q; ang_d = ang_q; tv_d = tv_q; fac_d = fac_q;
    ma = 33'sd0; mb = 33'sd0;
    dreq = '0; sq_start = 1'b0;
    for (int i = 0; i < 3; i++) begin
      spin_d[i] = spin_q[i]; tq_d[i] = tq_q[i]; ax_d[i] = ax_q[i];
    end
    case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          st_d = StCross; k_d = 3'd0;
        end
      end
      StCross: begin
        ma = v_q[cra(k_q)]; mb = f_q[crb(k_q)];
        if (!k_q[0]) begin
          acc_d = fq;
        end else begin
          tq_d[k_q[2:1]] = sat32(acc_q - fq);
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd5) begin
          st_d = StAcc; k_d = 3'd0;
        end
      end
      StAcc: begin
        ma = 33'(tq_q[ki]); mb = $signed({2'b00, inv_q});
        tq_d[ki] = sat32(fq);
        st_d = StInt;
      end
      StInt: begin
        ma = 33'(tq_q[ki]); mb = $signed({17'd0, step_q});
        spin_d[ki] = sat32(67'(spin_q[ki]) + fq);
        k_d = k_q + 3'd1;
        st_d = (k_q == 3'd2) ? StSq1 : StAcc;
        if (k_q == 3'd2) begin
          k_d = 3'd0; acc_d = '0;
        end
      end
      StSq1, StSq2: begin
        ma = 33'(spin_q[ki]); mb = 33'(spin_q[ki]);
        acc_d = acc_q + 67'(prod);
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) begin
          sq_start = 1'b1; k_d = 3'd0;
          ret_d = (st_q == StSq1) ? StRt1 : StRt2;
          st_d = StRWait;
        end else begin
          st_d = st_q;
        end
      end
      StRWait: begin
        if (sq_done) begin
          speed_d = sq_root; st_d = ret_q;
        end
      end
      StRt1: begin
        st_d = (speed_q > {2'b00, maxs_q}) ? StCapM : StLoss;
      end
      StCapM: begin
        ma = 33'(spin_q[ki]); mb = $signed({2'b00, maxs_q});
        dreq.start = 1'b1; dreq.num = 64'(prod); dreq.den = speed_q[31:0];
        ret_d = StCapD; st_d = StDWait;
      end
      StDWait: begin
        if (drsp.done) st_d = ret_q;
      end
      StCapD: begin
        spin_d[ki] = drsp.quo[31:0];
        k_d = k_q + 3'd1;
        st_d = StCapM;
        if (k_q == 3'd2) begin
          st_d = StLoss; k_d = 3'd0;
        end
      end
      StLoss: begin
        ma = $signed({16'd0, damp_q}); mb = $signed({17'd0, step_q});
        fac_d = (prod[65:16] >= 50'd65536) ? 17'd0 : 17'(17'd65536 - prod[32:16]);
        st_d = StDamp;
      end
      StDamp: begin
        ma = 33'(spin_q[ki]); mb = $signed({16'd0, fac_q});
        if (halt_q) spin_d[ki] = 32'sd0;
        else if (prod[65] && prod[15:0] != 16'd0) spin_d[ki] = 32'(prod[47:16] + 32'd1);
        else spin_d[ki] = prod[47:16];
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) begin
          st_d = StSq2; k_d = 3'd0; acc_d = '0;
        end
      end
      StRt2: begin
        ma = $signed({17'd0, step_q}); mb = $signed(speed_q);
        if (speed_q > {17'd0, rest_q}) begin
          tv_d = 1'b1;
          ang_d = (prod[65:47] != 19'd0) ? 31'h7fffffff : prod[46:16];
          st_d = StAxD;
        end else begin
          tv_d = 1'b0; ang_d = '0;
          for (int i = 0; i < 3; i++) ax_d[i] = '0;
          st_d = StOut;
        end
      end
      StAxD: begin
        dreq.start = 1'b1; dreq.num = {{16{spin_q[ki][31]}}, spin_q[ki], 16'd0};
        dreq.den = speed_q[31:0];
        ret_d = StAng; st_d = StDWait;
      end
      StAng: begin
        ax_d[ki] = drsp.quo[17:0];
        k_d = k_q + 3'd1;
        st_d = StAxD;
        if (k_q == 3'd2) begin
          st_d = StOut; k_d = 3'd0;
        end
      end
      StOut: begin
        if (m_axis_tready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ret_q <= StIdle; k_q <= 3'd0;
      spin_q[0] <= tdsi_pkg::SpinResetX;
      spin_q[1] <= tdsi_pkg::SpinResetY;
      spin_q[2] <= tdsi_pkg::SpinResetZ;
      inv_q  <= tdsi_pkg::InvInertiaReset;
      maxs_q <= tdsi_pkg::MaxSpeedReset;
      damp_q <= tdsi_pkg::DampingReset;
      rest_q <= tdsi_pkg::RestThrReset;
    end else begin
      st_q <= st_d; ret_q <= ret_d; k_q <= k_d;
      for (int i = 0; i < 3; i++) spin_q[i] <= spin_d[i];
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tdsi_pkg::RegInvInertia: inv_q  <= cfg_data_i[30:0];
          tdsi_pkg::RegMaxSpeed:   maxs_q <= cfg_data_i[30:0];
          tdsi_pkg::RegDamping:    damp_q <= cfg_data_i[16:0];
          tdsi_pkg::RegRestThr:    rest_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers and request capture.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; speed_q <= speed_d; ang_q <= ang_d; tv_q <= tv_d;
    fac_q <= fac_d;
    for (int i = 0; i < 3; i++) begin
      tq_q[i] <= tq_d[i]; ax_q[i] <= ax_d[i];
    end
    if (st_q == StIdle && s_axis_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= 33'($signed(s_axis_tdata[32*i +: 32]))
                - 33'($signed(s_axis_tdata[32*(i+3) +: 32]));
        f_q[i] <= 33'sd0 - 33'($signed(s_axis_tdata[32*(i+6) +: 32]));
      end
      step_q <= s_axis_tdata[303:288];
      halt_q <= s_axis_tuser;
    end
  end

  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = {3'd0, ang_q, ax_q[2], ax_q[1], ax_q[0],
                          spin_q[2], spin_q[1], spin_q[0]};
  assign m_axis_tuser  = tv_q;

endmodule

// ===== rtl/core/tdsi_checker.sv =====
// ----------------------------------------------------------------------------
// tdsi_checker: port-level checks of the spin integrator
// Watches the stream handshakes and the at-rest angle of the top level and is
// bound to it.
module tdsi_port_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // The input is never ready while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready with pending result");

  // An accepted request leaves the input busy next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // No rotation flag means no angle.
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[180:150] == 31'd0)
    else $error("angle at rest");

endmodule

bind torque_driven_spin_integrator tdsi_port_checker u_tdsi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser));
